/* design/ecd_pkg.sv */
// Shared types, constants and the segment table for the encoder counter display.
// No dependencies.
`default_nettype none

package ecd_pkg;

  localparam logic [15:0] DebForce = 16'hE000;
  localparam logic [15:0] DebPress = 16'hF000;
  localparam logic [7:0]  SegBlank = 8'hFF;
  localparam logic [3:0]  EncReset = 4'hF;

  // encoder pair codes
  localparam logic [1:0] PairHigh = 2'b11;
  localparam logic [1:0] PairDown = 2'b10;
  localparam logic [1:0] PairUp   = 2'b01;

  // mode codes
  localparam logic [1:0] ModeX1  = 2'd0;
  localparam logic [1:0] ModeX2  = 2'd1;
  localparam logic [1:0] ModeX4  = 2'd2;
  localparam logic [1:0] ModeOff = 2'd3;

  typedef struct packed {
    logic [1:0] buttons_n;
    logic [3:0] encoder_bits;
  } in_t;

  typedef struct packed {
    logic [9:0] count;
    logic [1:0] mode;
    logic [7:0] seg_thousands;
    logic [7:0] seg_hundreds;
    logic [7:0] seg_tens;
    logic [7:0] seg_ones;
  } out_t;

  // classified tick: signed step times scale, plus the mode after the tick
  typedef struct packed {
    logic       down;
    logic [2:0] mag;
    logic [1:0] mode;
  } delta_t;

  function automatic logic [7:0] seg_code(input logic [3:0] d);
    logic [7:0] c;
    case (d)
      4'd0: c = 8'hC0;
      4'd1: c = 8'hF9;
      4'd2: c = 8'hA4;
      4'd3: c = 8'hB0;
      4'd4: c = 8'h99;
      4'd5: c = 8'h92;
      4'd6: c = 8'h82;
      4'd7: c = 8'hF8;
      4'd8: c = 8'h80;
      4'd9: c = 8'h90;
      default: c = SegBlank;
    endcase
    return c;
  endfunction

  // add or subtract k (0..4) to a four-digit BCD value; a carry or borrow out of the top digit is dropped
  function automatic logic [3:0][3:0] bcd_step(input logic [3:0][3:0] d,
                                               input logic [2:0] k,
                                               input logic down);
    logic [3:0][3:0] r;
    logic [4:0] c;
    logic [4:0] t;
    c = {2'b00, k};
    for (int i = 0; i < 4; i++) begin
      if (down) begin
        if ({1'b0, d[i]} < c) begin
          t = {1'b0, d[i]} + 5'd10 - c;
          c = 5'd1;
        end else begin
          t = {1'b0, d[i]} - c;
          c = 5'd0;
        end
      end else begin
        t = {1'b0, d[i]} + c;
        if (t > 5'd9) begin
          t = t - 5'd10;
          c = 5'd1;
        end else begin
          c = 5'd0;
        end
      end
      r[i] = t[3:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* design/ecd_front.sv */
// Front end: button debounce, mode toggles and encoder transition decode.
// Depends on ecd_pkg.
`default_nettype none

module ecd_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           accept_i,
  input  wire ecd_pkg::in_t   in_i,
  output      ecd_pkg::delta_t delta_o
);
  import ecd_pkg::*;

  logic [1:0][15:0] hist_q, hist_d;
  logic [1:0]       mode_q, mode_d;
  logic [3:0]       prev_q;
  logic [2:0]       scale;
  logic             step_nz, step_dn;

  always_comb begin
    mode_d = mode_q;
    for (int b = 0; b < 2; b++) begin
      hist_d[b] = {hist_q[b][14:0], in_i.buttons_n[b]} | DebForce;
      if (hist_d[b] == DebPress) mode_d[b] = ~mode_q[b];
    end
  end

  always_comb begin
    case (mode_d)
      ModeX1:  scale = 3'd1;
      ModeX2:  scale = 3'd2;
      ModeX4:  scale = 3'd4;
      ModeOff: scale = 3'd0;
      default: scale = 3'd0;
    endcase
  end

  // pair A first; pair B only if A gives no step
  always_comb begin
    step_nz = 1'b0;
    step_dn = 1'b0;
    if (in_i.encoder_bits != prev_q) begin
      if (in_i.encoder_bits[1:0] == PairHigh &&
          (prev_q[1:0] == PairDown || prev_q[1:0] == PairUp)) begin
        step_nz = 1'b1;
        step_dn = (prev_q[1:0] == PairDown);
      end else if (in_i.encoder_bits[3:2] == PairHigh &&
                   (prev_q[3:2] == PairDown || prev_q[3:2] == PairUp)) begin
        step_nz = 1'b1;
        step_dn = (prev_q[3:2] == PairDown);
      end
    end
  end

  assign delta_o.down = step_dn;
  assign delta_o.mag  = step_nz ? scale : 3'd0;
  assign delta_o.mode = mode_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
      mode_q <= '0;
      prev_q <= EncReset;
    end else if (accept_i) begin
      hist_q <= hist_d;
      mode_q <= mode_d;
      prev_q <= in_i.encoder_bits;
    end
  end

endmodule

`default_nettype wire

/* design/ecd_fifo.sv */
// Two-entry queue of classified ticks between front and back.
// Depends on ecd_pkg.
`default_nettype none

module ecd_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire ecd_pkg::delta_t data_i,
  output      logic            full_o,
  output      logic            nempty_o,
  input  wire logic            pop_i,
  output      ecd_pkg::delta_t data_o
);
  import ecd_pkg::*;

  delta_t [1:0] mem_q;
  logic         wr_q, rd_q;
  logic [1:0]   cnt_q;

  assign full_o   = cnt_q[1];
  assign nempty_o = (cnt_q != 2'd0);
  assign data_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

/* design/ecd_back.sv */
// Back end: saturating count, parallel BCD digits, segment codes, output register.
// Depends on ecd_pkg.
`default_nettype none

module ecd_back #(
  parameter int COUNT_MAX = 1023
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            q_nempty_i,
  input  wire ecd_pkg::delta_t q_data_i,
  output      logic            q_pop_o,
  output      logic            out_valid_o,
  input  wire logic            out_stall_i,
  output      ecd_pkg::out_t   out_o
);
  import ecd_pkg::*;

  localparam int CntW = $clog2(COUNT_MAX + 1);
  localparam int SumW = CntW + 3;
  localparam logic [SumW-1:0] MaxS = SumW'(COUNT_MAX);
  localparam logic [3:0] Max3 = 4'((COUNT_MAX / 1000) % 10);
  localparam logic [3:0] Max2 = 4'((COUNT_MAX / 100) % 10);
  localparam logic [3:0] Max1 = 4'((COUNT_MAX / 10) % 10);
  localparam logic [3:0] Max0 = 4'(COUNT_MAX % 10);

  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [3:0][3:0]  bcd_q, bcd_d;
  logic [SumW-1:0]  cnt_s, mag_s, sum_s, diff_s;
  logic             under, over;
  logic [CntW+9:0]  cnt_ext;
  logic             out_valid_q;
  out_t             out_q, out_d;

  assign q_pop_o = q_nempty_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    cnt_s  = {3'b000, cnt_q};
    mag_s  = {{(SumW-3){1'b0}}, q_data_i.mag};
    sum_s  = cnt_s + mag_s;
    diff_s = cnt_s - mag_s;
    under  = q_data_i.down && (cnt_s < mag_s);
    over   = !q_data_i.down && (sum_s > MaxS);
    if (under) begin
      cnt_d = '0;
      bcd_d = '0;
    end else if (over) begin
      cnt_d = MaxS[CntW-1:0];
      bcd_d = {Max3, Max2, Max1, Max0};
    end else begin
      cnt_d = q_data_i.down ? diff_s[CntW-1:0] : sum_s[CntW-1:0];
      bcd_d = bcd_step(bcd_q, q_data_i.mag, q_data_i.down);
    end
  end

  // leading-zero blanking, ones digit always lit
  always_comb begin
    cnt_ext             = {10'b0, cnt_d};
    out_d.count         = cnt_ext[9:0];
    out_d.mode          = q_data_i.mode;
    out_d.seg_thousands = (bcd_d[3] == 4'd0) ? SegBlank : seg_code(bcd_d[3]);
    out_d.seg_hundreds  = (bcd_d[3:2] == 8'd0) ? SegBlank : seg_code(bcd_d[2]);
    out_d.seg_tens      = (bcd_d[3:1] == 12'd0) ? SegBlank : seg_code(bcd_d[1]);
    out_d.seg_ones      = seg_code(bcd_d[0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      bcd_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        cnt_q       <= cnt_d;
        bcd_q       <= bcd_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

/* design/encoder_counter_display.sv */
// Top level of the encoder counter display: front end, tick queue, back end.
// Depends on ecd_pkg, ecd_front, ecd_fifo, ecd_back.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_i): one beat per sample tick,
//   carrying the active-low button levels and the four encoder bits.
//   Output channel (out_valid_o / out_stall_i / out_o): one beat per input
//   beat, in order: saturated count, mode and four active-low digit codes
//   with up to three leading zeros blanked.
//   Path: a beat taken is written to the queue, moves into the output register
//   once that register is free, and is offered to the receiver from then on.
//   Throughput: one beat per cycle while the receiver does not stall. The
//   front end decodes buttons and encoder; the back end applies one queued
//   step per cycle, and the count and its BCD digits are updated side by
//   side, so no division runs.
//   Stall: the two-entry queue lets the front keep taking beats while a
//   result waits; in_stall_o rises only once both entries are occupied.
//   Reset (rst_ni low, async): debounce history, mode and count clear,
//   previous encoder sample is all ones, queue and output register empty.
`default_nettype none

module encoder_counter_display #(
  parameter int COUNT_MAX = 1023
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output      logic          in_stall_o,
  input  wire ecd_pkg::in_t  in_i,
  output      logic          out_valid_o,
  input  wire logic          out_stall_i,
  output      ecd_pkg::out_t out_o
);
  import ecd_pkg::*;

  delta_t front_delta, q_delta;
  logic   accept, q_full, q_nempty, q_pop;

  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  // classify each tick against front state
  ecd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .in_i     (in_i),
    .delta_o  (front_delta)
  );

  // decouples front from output backpressure
  ecd_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (accept),
    .data_i   (front_delta),
    .full_o   (q_full),
    .nempty_o (q_nempty),
    .pop_i    (q_pop),
    .data_o   (q_delta)
  );

  // count update and display encode
  ecd_back #(
    .COUNT_MAX (COUNT_MAX)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_nempty_i  (q_nempty),
    .q_data_i    (q_delta),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

/* design/ecd_checker.sv */
// Port-level checks for the encoder counter display, bound to the top level.
// Depends on ecd_pkg and encoder_counter_display.
`default_nettype none

module ecd_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_valid_i,
  input wire logic          in_stall_o,
  input wire ecd_pkg::in_t  in_i,
  input wire logic          out_valid_o,
  input wire logic          out_stall_i,
  input wire ecd_pkg::out_t out_o
);
  import ecd_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_o))
    else $error("stalled output beat changed");

  a_ones_lit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_o.seg_ones != SegBlank)
    else $error("ones digit blanked");

  // blanking only runs from the left
  a_blank_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_o.seg_tens == SegBlank || out_o.seg_hundreds == SegBlank)
      |-> out_o.seg_thousands == SegBlank)
    else $error("blank digit right of a lit one");

  // queue write, then output register: an accepted beat comes out as a result
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |-> ##2 out_valid_o)
    else $error("no result after accepted beat");

endmodule

bind encoder_counter_display ecd_checker u_ecd_checker (.*);

`default_nettype wire

/* dv/testbench.sv */
// Self-checking bench for encoder_counter_display: debounced mode buttons, quadrature steps,
// saturating count and blanked 7-segment digits, checked beat by beat against a local predictor.
// Depends on ecd_pkg (in_t, out_t, mode and pair codes) and the encoder_counter_display RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ecd_pkg::*;

  localparam int CountTop    = 1023;
  localparam int TickBudget  = 950;     // stimulus stops once this many ticks are in
  localparam int CycleLimit  = 200000;  // watchdog limit on the whole run
  localparam int PressHold   = 12;      // zero samples needed for one debounced press
  localparam int LongStall   = 90;      // receiver hold-off in the backpressure test

  // active-low glyphs, digit 0 in the low byte
  localparam logic [9:0][7:0] DigitGlyph = {
    8'h90, 8'h80, 8'hF8, 8'h82, 8'h92, 8'h99, 8'hB0, 8'hA4, 8'hF9, 8'hC0
  };

  logic clk;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_o;

  encoder_counter_display #(
    .COUNT_MAX(CountTop)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out_o)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of what the block holds after each tick.
  // ---------------------------------------------------------------------------
  logic [15:0] hist_q [2];
  logic [1:0]  mode_q;
  logic [3:0]  enc_q;
  int          count_q;

  out_t expected_q [$];   // displays still owed by the block, oldest first

  // run statistics
  int ticks_sent;
  int results_seen;
  int mismatches;
  int mode_toggles;
  int clamp_hits;
  int backpressure_cycles;
  int cycle_cnt;

  // what the driver currently presents on the encoder and button lines
  logic [3:0] enc_drive;
  logic [1:0] btn_drive;

  // idling controls: quiet means no gap on that side
  bit tx_quiet;
  bit rx_quiet;
  int hold_req;   // one-shot long stall request for the receiver

  // Direction of one pair: a move into 11 from 10 is down, from 01 is up.
  function automatic int pair_dir(input logic [1:0] now_v, input logic [1:0] was_v);
    if (now_v == PairHigh) begin
      if (was_v == PairDown) return -1;
      if (was_v == PairUp) return 1;
    end
    return 0;
  endfunction

  // One sample tick: debounce, mode toggle, encoder step, saturating count, display.
  function automatic out_t advance_counter(input in_t beat);
    logic [15:0] h;
    int          scale;
    int          dir;
    int          nxt;
    logic [7:0]  glyph [4];
    logic        leading;
    out_t        r;
    for (int b = 0; b < 2; b++) begin
      h = {hist_q[b][14:0], beat.buttons_n[b]} | DebForce;
      hist_q[b] = h;
      if (h == DebPress) begin
        mode_q[b] = ~mode_q[b];
        mode_toggles++;
      end
    end
    // scale follows the mode after this tick's presses
    case (mode_q)
      ModeX1:  scale = 1;
      ModeX2:  scale = 2;
      ModeX4:  scale = 4;
      default: scale = 0;
    endcase
    dir = 0;
    if (beat.encoder_bits != enc_q) begin
      // pair A wins; pair B only counts when A gave nothing
      dir = pair_dir(beat.encoder_bits[1:0], enc_q[1:0]);
      if (dir == 0) dir = pair_dir(beat.encoder_bits[3:2], enc_q[3:2]);
      enc_q = beat.encoder_bits;
    end
    nxt = count_q + dir * scale;
    if (nxt < 0 || nxt > CountTop) clamp_hits++;
    if (nxt < 0) nxt = 0;
    if (nxt > CountTop) nxt = CountTop;
    count_q = nxt;
    glyph[0] = DigitGlyph[4'((nxt / 1000) % 10)];
    glyph[1] = DigitGlyph[4'((nxt / 100) % 10)];
    glyph[2] = DigitGlyph[4'((nxt / 10) % 10)];
    glyph[3] = DigitGlyph[4'(nxt % 10)];
    // blank leading zeros, never the ones digit
    leading = 1'b1;
    for (int k = 0; k < 3; k++) begin
      if (leading && glyph[k] == DigitGlyph[0]) glyph[k] = SegBlank;
      else leading = 1'b0;
    end
    r.count         = 10'(nxt);
    r.mode          = mode_q;
    r.seg_thousands = glyph[0];
    r.seg_hundreds  = glyph[1];
    r.seg_tens      = glyph[2];
    r.seg_ones      = glyph[3];
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: every beat taken on the output pops the oldest expectation.
  // Sampled at the rising edge, before the block's registers move.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    out_t want;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (expected_q.size() == 0) begin
        $error("display beat with no tick pending: count %0h", out_o.count);
        mismatches++;
      end else begin
        want = expected_q.pop_front();
        check_field("count", 16'(want.count), 16'(out_o.count));
        check_field("mode", 16'(want.mode), 16'(out_o.mode));
        check_field("seg_thousands", 16'(want.seg_thousands), 16'(out_o.seg_thousands));
        check_field("seg_hundreds", 16'(want.seg_hundreds), 16'(out_o.seg_hundreds));
        check_field("seg_tens", 16'(want.seg_tens), 16'(out_o.seg_tens));
        check_field("seg_ones", 16'(want.seg_ones), 16'(out_o.seg_ones));
        results_seen++;
      end
    end
  end

  // Watchdog and backpressure counter.
  always @(posedge clk) begin
    cycle_cnt++;
    if (in_valid_i && in_stall_o === 1'b1) backpressure_cycles++;
    if (cycle_cnt == CycleLimit) begin
      $display("timeout after %0d cycles, %0d displays outstanding", cycle_cnt,
               expected_q.size());
      $display("testbench: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: before each beat it stalls for a random hold, or the long hold-off
  // when one is requested. The hold is counted here, in this process, while
  // the sender keeps offering beats.
  // ---------------------------------------------------------------------------
  initial begin : drain_displays
    int hold;
    out_stall_i = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req > 0) begin
        hold     = hold_req;
        hold_req = 0;
      end else begin
        hold = rx_quiet ? 0 : $urandom_range(0, 11);
      end
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk); while (out_valid_o !== 1'b1);
      @(negedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // Sender. Called at a falling edge, returns at a falling edge. Valid stays
  // high into the next call, which either keeps it up with a new payload or
  // drops it for the drawn gap.
  // ---------------------------------------------------------------------------
  task automatic send_tick(input in_t beat);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid_i <= 1'b1;
    in_i       <= beat;
    do @(posedge clk); while (in_stall_o !== 1'b0);
    expected_q.push_back(advance_counter(beat));
    ticks_sent++;
    @(negedge clk);
  endtask

  // one tick with whatever the lines currently hold
  task automatic tick();
    in_t b;
    b.buttons_n    = btn_drive;
    b.encoder_bits = enc_drive;
    send_tick(b);
  endtask

  task automatic put_pair(input bit pair_b, input logic [1:0] v);
    if (pair_b) enc_drive[3:2] = v;
    else enc_drive[1:0] = v;
  endtask

  // Gray-code turning of one pair: up is 00-01-11-10, down the reverse.
  task automatic quad_move(input bit pair_b, input bit up, input int n);
    logic [1:0] cur;
    repeat (n) begin
      cur = pair_b ? enc_drive[3:2] : enc_drive[1:0];
      put_pair(pair_b, up ? {cur[0], ~cur[1]} : {~cur[0], cur[1]});
      tick();
    end
  endtask

  // Fastest single step: park the pair on 01 or 10, then enter 11.
  task automatic nudge(input bit pair_b, input bit up);
    put_pair(pair_b, up ? PairUp : PairDown);
    tick();
    put_pair(pair_b, PairHigh);
    tick();
  endtask

  // Release for one tick, hold the masked buttons low, release again.
  // Twelve or more low samples give exactly one toggle; fewer is a bounce.
  task automatic press(input logic [1:0] mask, input int hold, input bit noisy);
    btn_drive = btn_drive | mask;
    tick();
    btn_drive = btn_drive & ~mask;
    repeat (hold) begin
      if (noisy) enc_drive = 4'($urandom_range(0, 15));
      tick();
    end
    btn_drive = btn_drive | mask;
  endtask

  task automatic select_mode(input logic [1:0] target);
    while (mode_q != target) press(mode_q ^ target, PressHold + $urandom_range(0, 3), 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Pair edges from the reset sample of all ones: each direction on each pair,
  // both pairs entering 11 together (A wins), moves that do not end in 11,
  // repeated samples, underflow at zero, and short button dips.
  task automatic test_encoder_edges();
    logic [5:0] seq [22];
    seq = '{
      {2'b11, 4'hF}, {2'b00, 4'hE}, {2'b00, 4'hF}, {2'b01, 4'hD}, {2'b10, 4'hF},
      {2'b11, 4'hB}, {2'b11, 4'hF}, {2'b11, 4'h7}, {2'b11, 4'hF}, {2'b11, 4'h5},
      {2'b11, 4'hF}, {2'b11, 4'h6}, {2'b11, 4'hF}, {2'b11, 4'h9}, {2'b11, 4'hF},
      {2'b11, 4'h0}, {2'b11, 4'hF}, {2'b11, 4'h3}, {2'b11, 4'h7}, {2'b11, 4'hF},
      {2'b11, 4'hC}, {2'b11, 4'hE}
    };
    foreach (seq[i]) send_tick(in_t'(seq[i]));
    enc_drive = 4'hE;
    tick();   // A held at 10 once more before it enters 11
    enc_drive = 4'hF;
    tick();
  endtask

  // Walk through all four modes with single and double presses, a bounce that
  // must not toggle, a zero scale, and underflow at the largest scale.
  task automatic test_mode_cycle();
    select_mode(ModeX2);
    quad_move(1'b0, 1'b1, 8);
    quad_move(1'b1, 1'b0, 4);
    press(2'b10, PressHold - 1, 1'b0);   // one sample short: bounce
    select_mode(ModeOff);
    repeat (3) nudge(1'b0, 1'b1);        // scale zero, count frozen
    select_mode(ModeX4);
    repeat (4) nudge(1'b1, 1'b0);        // saturate at the bottom
    repeat (2) nudge(1'b0, 1'b1);
    select_mode(ModeX1);
    press(2'b11, PressHold + 2, 1'b1);   // both buttons at once, noisy encoder
    press(2'b11, PressHold, 1'b0);
    select_mode(ModeX1);
  endtask

  // Climb at scale four through every display width up to the top, then push
  // past it. The first stretch runs with no idling on either side.
  task automatic test_climb_to_top();
    int steps;
    select_mode(ModeX4);
    steps    = 0;
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    while (count_q < CountTop) begin
      if (steps == 100) begin
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
      end
      nudge($urandom_range(0, 1), 1'b1);
      steps++;
    end
    repeat (6) nudge($urandom_range(0, 1), 1'b1);
  endtask

  // Receiver holds off for a long stretch while the sender streams beats
  // back to back, so the queue fills and the input stalls.
  task automatic test_backpressure();
    hold_req = LongStall;
    tx_quiet = 1'b1;
    repeat (20) nudge($urandom_range(0, 1), 1'b0);
    tx_quiet = 1'b0;
  endtask

  // Mostly well-formed motion and presses with random content, plus bounces,
  // raw noise on every line and repeated samples.
  task automatic test_random_walk();
    int kind;
    int n;
    while (ticks_sent < TickBudget) begin
      tx_quiet = ($urandom_range(0, 4) == 0);
      rx_quiet = ($urandom_range(0, 4) == 0);
      kind     = $urandom_range(0, 9);
      n        = $urandom_range(1, 12);
      case (kind)
        0, 1, 2, 3: quad_move($urandom_range(0, 1), $urandom_range(0, 1), n);
        4, 5: repeat (n) nudge($urandom_range(0, 1), $urandom_range(0, 1));
        6: press(2'($urandom_range(1, 3)), PressHold + $urandom_range(0, 4),
                 $urandom_range(0, 1));
        7: press(2'($urandom_range(1, 3)), $urandom_range(1, PressHold - 1), 1'b0);
        8: begin
          repeat (n) begin
            btn_drive = 2'($urandom_range(0, 3));
            enc_drive = 4'($urandom_range(0, 15));
            tick();
          end
          btn_drive = 2'b11;
        end
        default: repeat (n) tick();
      endcase
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    in_valid_i = 1'b0;
    in_i       = '0;
    rst_ni     = 1'b0;
    hist_q[0]  = '0;
    hist_q[1]  = '0;
    mode_q     = ModeX1;
    enc_q      = EncReset;
    count_q    = 0;
    enc_drive  = EncReset;
    btn_drive  = 2'b11;
    tx_quiet   = 1'b0;
    rx_quiet   = 1'b0;
    hold_req   = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    test_encoder_edges();
    test_mode_cycle();
    test_climb_to_top();
    test_backpressure();
    test_random_walk();

    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);   // anything extra would show up here

    $display("summary: %0d ticks sent, %0d displays checked, %0d mode toggles",
             ticks_sent, results_seen, mode_toggles);
    $display("summary: %0d saturating steps, %0d cycles with the input stalled",
             clamp_hits, backpressure_cycles);
    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
